// ----- hw/rtl/cad_pkg.sv -----
package cad_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ATTEMPTS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CAD_TIMEOUT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_MIN     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_MAX     = 3'd4;

    localparam logic [3:0]  RST_MAX_ATTEMPTS = 4'd3;
    localparam logic [15:0] RST_CAD_TIMEOUT  = 16'd100;
    localparam logic [7:0]  RST_SETTLE       = 8'd2;
    localparam logic [13:0] RST_BASE_MIN     = 14'd100;
    localparam logic [13:0] RST_BASE_MAX     = 14'd500;

    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_TICK  = 2'd1;
    localparam logic [1:0] FN_DONE  = 2'd2;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_SETTLE  = 2'd1;
    localparam logic [1:0] PH_DETECT  = 2'd2;
    localparam logic [1:0] PH_BACKOFF = 2'd3;

    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_IDLE   = 2'd1;
    localparam logic [1:0] CMD_DETECT = 2'd2;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_FREE = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic latch;
        logic div_start;
        logic commit;
    } cad_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } cad_sts_t;

endpackage

// ----- hw/rtl/cad_div.sv -----
module cad_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] rem
);
    import cad_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] div_reg, div_next;
    logic [15:0] rem_reg, rem_next;
    logic [16:0] trial;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        trial      = {rem_reg, shift_reg[31]};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            div_next   = divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            // one restoring step per cycle
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = 16'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[15:0];
            end
            shift_next = {shift_reg[30:0], 1'b0};
            cnt_next   = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- hw/rtl/cad_dp.sv -----
module cad_dp #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cad_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [cad_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [cad_pkg::IN_USER_W-1:0]       s_tuser,
    input  logic [cad_pkg::IN_DATA_W-1:0]       s_tdata,
    input  cad_pkg::cad_cmd_t                   cmd,
    output cad_pkg::cad_sts_t                   sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cad_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import cad_pkg::*;

    localparam logic [63:0] CMAX64 = (64'd1 << COUNTER_WIDTH) - 64'd1;
    localparam logic [31:0] CMAX   = CMAX64[31:0];

    function automatic logic [COUNTER_WIDTH-1:0] ctr_load(input logic [31:0] v);
        logic [COUNTER_WIDTH-1:0] r;
        if (v > CMAX)
        begin
            r = CMAX[COUNTER_WIDTH-1:0];
        end
        else
        begin
            r = v[COUNTER_WIDTH-1:0];
        end
        return r;
    endfunction

    logic [3:0]  max_att_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  settle_reg;
    logic [13:0] base_min_reg;
    logic [13:0] base_max_reg;

    logic [1:0]               phase_reg, phase_next;
    logic [3:0]               att_reg, att_next;
    logic [COUNTER_WIDTH-1:0] tick_reg, tick_next;

    logic [1:0]  in_func_reg;
    logic        in_det_reg;
    logic [31:0] in_rnd_reg;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_cmd_reg, out_cmd_next;
    logic [1:0]  out_st_reg, out_st_next;
    logic [3:0]  out_att_reg;
    logic [15:0] out_bo_reg, out_bo_next;

    logic [1:0]  sh;
    logic [15:0] lo, hi, span, bo_drawn;
    logic        inverted;
    logic [3:0]  att_inc;
    logic        div_done;
    logic [15:0] div_rem;

    always_comb
    begin
        sh       = (att_reg < 4'd2) ? att_reg[1:0] : 2'd2;
        lo       = 16'(base_min_reg) << sh;
        hi       = 16'(base_max_reg) << sh;
        inverted = hi < lo;
        span     = hi - lo + 16'd1;
        bo_drawn = inverted ? lo : 16'(lo + div_rem);
        att_inc  = att_reg + 4'd1;
    end

    cad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (in_rnd_reg),
        .divisor  (span),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign sts.need_div = (in_func_reg == FN_DONE) && (phase_reg == PH_DETECT)
                          && in_det_reg && !inverted;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        phase_next   = phase_reg;
        att_next     = att_reg;
        tick_next    = tick_reg;
        out_cmd_next = CMD_NONE;
        out_st_next  = ST_RUN;
        out_bo_next  = '0;
        case (in_func_reg)
            FN_START:
            begin
                att_next     = '0;
                out_cmd_next = CMD_IDLE;
                phase_next   = PH_SETTLE;
                tick_next    = ctr_load(32'(settle_reg));
            end
            FN_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (tick_reg > COUNTER_WIDTH'(1))
                    begin
                        tick_next = tick_reg - COUNTER_WIDTH'(1);
                    end
                    else if (phase_reg == PH_SETTLE)
                    begin
                        out_cmd_next = CMD_DETECT;
                        phase_next   = PH_DETECT;
                        tick_next    = ctr_load(32'(timeout_reg));
                    end
                    else
                    begin
                        // timeout or backoff expiry ends the attempt
                        att_next     = att_inc;
                        out_cmd_next = CMD_IDLE;
                        if (att_inc >= max_att_reg)
                        begin
                            out_st_next = ST_FAIL;
                            phase_next  = PH_IDLE;
                            tick_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_SETTLE;
                            tick_next  = ctr_load(32'(settle_reg));
                        end
                    end
                end
            end
            FN_DONE:
            begin
                if (phase_reg == PH_DETECT)
                begin
                    if (!in_det_reg)
                    begin
                        out_st_next = ST_FREE;
                        phase_next  = PH_IDLE;
                        tick_next   = '0;
                    end
                    else
                    begin
                        out_bo_next  = bo_drawn;
                        out_cmd_next = CMD_IDLE;
                        phase_next   = PH_BACKOFF;
                        tick_next    = ctr_load(32'(bo_drawn));
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_att_reg   <= RST_MAX_ATTEMPTS;
            timeout_reg   <= RST_CAD_TIMEOUT;
            settle_reg    <= RST_SETTLE;
            base_min_reg  <= RST_BASE_MIN;
            base_max_reg  <= RST_BASE_MAX;
            phase_reg     <= PH_IDLE;
            att_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MAX_ATTEMPTS: max_att_reg  <= cfg_wdata[3:0];
                    REG_CAD_TIMEOUT:  timeout_reg  <= cfg_wdata[15:0];
                    REG_SETTLE:       settle_reg   <= cfg_wdata[7:0];
                    REG_BASE_MIN:     base_min_reg <= cfg_wdata[13:0];
                    REG_BASE_MAX:     base_max_reg <= cfg_wdata[13:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit)
            begin
                phase_reg <= phase_next;
                att_reg   <= att_next;
                tick_reg  <= tick_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            in_func_reg <= s_tuser[1:0];
            in_det_reg  <= s_tdata[0];
            in_rnd_reg  <= s_tdata[32:1];
        end
        if (cmd.commit)
        begin
            out_cmd_reg <= out_cmd_next;
            out_st_reg  <= out_st_next;
            out_att_reg <= att_next;
            out_bo_reg  <= out_bo_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_bo_reg, out_att_reg, out_st_reg, out_cmd_reg};

endmodule

// ----- hw/rtl/cad_ctrl.sv -----
module cad_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cad_pkg::cad_sts_t sts,
    output cad_pkg::cad_cmd_t cmd
);
    import cad_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.latch     = 1'b0;
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        s_tready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/cad_channel_access_backoff.sv -----
// the input beat is latched, then committed to the output registers once the
// output is free; a busy detection result that draws a backoff first waits on
// the 32-step restoring remainder unit (one dividend bit per cycle)
// one beat at a time: no new beat is taken until the current one is committed
// reset (async, active low): registers to defaults, phase idle, attempt 0
module cad_channel_access_backoff #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cad_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [cad_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // detected, random_word, zero pad
    input  logic [cad_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // func
    input  logic [cad_pkg::IN_USER_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // radio_cmd, status, attempt, backoff_ticks
    output logic [cad_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import cad_pkg::*;

    cad_cmd_t cmd;
    cad_sts_t sts;

    cad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cad_dp #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_axis_tuser),
        .s_tdata   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again while a beat is in work");

    a_free_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3:2] == ST_FREE |-> m_axis_tdata[1:0] == CMD_NONE)
        else $error("free channel reported with a radio command");

    a_fail_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3:2] == ST_FAIL |-> m_axis_tdata[1:0] == CMD_IDLE)
        else $error("failure reported without idle command");

    a_backoff_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[23:8] != 16'd0 |->
        m_axis_tdata[1:0] == CMD_IDLE && m_axis_tdata[3:2] == ST_RUN)
        else $error("backoff drawn without idle command");

endmodule

// ----- tb/cad_channel_access_backoff_tb.sv -----
`timescale 1ns / 1ps

module cad_channel_access_backoff_tb;
    import cad_pkg::*;

    localparam int CNT_W = 16;
    localparam logic [31:0] CNT_MAX = 32'((64'd1 << CNT_W) - 64'd1);
    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_EVENTS = 100;
    localparam int RANDOM_PHASES = 8;

    typedef struct packed {
        logic [15:0] backoff;
        logic [3:0]  attempt;
        logic [1:0]  status;
        logic [1:0]  cmd;
    } chan_result_t;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [1:0]               fn;
        logic                     det;
        logic [31:0]              rnd;
        logic [CFG_ADDR_W-1:0]    addr;
        logic [CFG_DATA_W-1:0]    wdata;
        bit                       typed;
        chan_result_t             res;
    } plan_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // detected, random_word, zero pad
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    // func
    logic [IN_USER_W-1:0]    s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // radio_cmd, status, attempt, backoff_ticks
    logic [OUT_DATA_W-1:0]   m_axis_tdata;

    // predictor copy of registers and state
    logic [3:0]  reg_max_att;
    logic [15:0] reg_timeout;
    logic [7:0]  reg_settle;
    logic [13:0] reg_base_min;
    logic [13:0] reg_base_max;
    logic [1:0]  fsm_phase;
    logic [3:0]  attempt_cnt;
    logic [31:0] tick_cnt;

    chan_result_t pending_results[$];
    plan_row_t    plan[$];
    int           bad_beats = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           quiet_cycles = 0;

    cad_channel_access_backoff #(
        .COUNTER_WIDTH(CNT_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] load_counter(input logic [31:0] v);
        return (v > CNT_MAX) ? CNT_MAX : v;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_ADDR_W-1:0] addr,
                                            input logic [CFG_DATA_W-1:0] data);
        case (addr)
            REG_MAX_ATTEMPTS: reg_max_att  = data[3:0];
            REG_CAD_TIMEOUT:  reg_timeout  = data[15:0];
            REG_SETTLE:       reg_settle   = data[7:0];
            REG_BASE_MIN:     reg_base_min = data[13:0];
            REG_BASE_MAX:     reg_base_max = data[13:0];
            default: ;
        endcase
    endfunction

    function automatic chan_result_t step_access_fsm(input logic [1:0] fn, input logic det,
                                                      input logic [31:0] rnd);
        chan_result_t r;
        logic [31:0]  shift;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  drawn;
        r = '0;
        case (fn)
            FN_START:
            begin
                attempt_cnt = '0;
                r.cmd = CMD_IDLE;
                fsm_phase = PH_SETTLE;
                tick_cnt = load_counter(32'(reg_settle));
            end
            FN_TICK:
            begin
                if (fsm_phase != PH_IDLE)
                begin
                    if (tick_cnt > 32'd1)
                        tick_cnt = tick_cnt - 32'd1;
                    else if (fsm_phase == PH_SETTLE)
                    begin
                        r.cmd = CMD_DETECT;
                        fsm_phase = PH_DETECT;
                        tick_cnt = load_counter(32'(reg_timeout));
                    end
                    else
                    begin
                        // detection timeout or end of backoff
                        attempt_cnt = attempt_cnt + 4'd1;
                        r.cmd = CMD_IDLE;
                        if (attempt_cnt >= reg_max_att)
                        begin
                            r.status = ST_FAIL;
                            fsm_phase = PH_IDLE;
                            tick_cnt = '0;
                        end
                        else
                        begin
                            fsm_phase = PH_SETTLE;
                            tick_cnt = load_counter(32'(reg_settle));
                        end
                    end
                end
            end
            FN_DONE:
            begin
                if (fsm_phase == PH_DETECT)
                begin
                    if (!det)
                    begin
                        r.status = ST_FREE;
                        fsm_phase = PH_IDLE;
                        tick_cnt = '0;
                    end
                    else
                    begin
                        shift = (attempt_cnt < 4'd2) ? 32'(attempt_cnt) : 32'd2;
                        lo = 32'(reg_base_min) << shift;
                        hi = 32'(reg_base_max) << shift;
                        drawn = (hi < lo) ? lo : lo + rnd % (hi - lo + 32'd1);
                        r.backoff = drawn[15:0];
                        r.cmd = CMD_IDLE;
                        fsm_phase = PH_BACKOFF;
                        tick_cnt = load_counter(drawn);
                    end
                end
            end
            default: ;
        endcase
        r.attempt = attempt_cnt;
        return r;
    endfunction

    function automatic chan_result_t mk_res(input logic [1:0] cmd, input logic [1:0] st,
                                            input logic [3:0] att, input logic [15:0] bo);
        chan_result_t r;
        r.cmd = cmd;
        r.status = st;
        r.attempt = att;
        r.backoff = bo;
        return r;
    endfunction

    function automatic plan_row_t row_beat(input logic [1:0] fn, input logic det,
                                           input logic [31:0] rnd);
        plan_row_t r;
        r = '{kind: ROW_BEAT, fn: fn, det: det, rnd: rnd, addr: '0, wdata: '0,
              typed: 1'b0, res: '0};
        return r;
    endfunction

    function automatic plan_row_t row_chk(input logic [1:0] fn, input logic det,
                                          input logic [31:0] rnd, input chan_result_t res);
        plan_row_t r;
        r = row_beat(fn, det, rnd);
        r.typed = 1'b1;
        r.res = res;
        return r;
    endfunction

    function automatic plan_row_t row_reg(input logic [CFG_ADDR_W-1:0] addr,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r = '{kind: ROW_REG, fn: FN_START, det: 1'b0, rnd: '0, addr: addr, wdata: data,
              typed: 1'b0, res: '0};
        return r;
    endfunction

    task automatic send_event(input logic [1:0] fn, input logic det, input logic [31:0] rnd,
                              input bit typed, input chan_result_t typed_res);
        chan_result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {{(IN_DATA_W - 33){1'b0}}, rnd, det};
        s_axis_tuser = fn;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = step_access_fsm(fn, det, rnd);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
        apply_reg_write(addr, data);
    endtask

    // receiver back-pressure
    always @(negedge clk)
        m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);

    // result checker
    always @(posedge clk)
    begin : result_check
        chan_result_t got;
        chan_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = chan_result_t'(m_axis_tdata);
            if (pending_results.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("unexpected result beat: cmd %0d status %0d attempt %0d backoff %0d",
                             got.cmd, got.status, got.attempt, got.backoff);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.cmd !== want.cmd || got.status !== want.status ||
                    got.attempt !== want.attempt || got.backoff !== want.backoff)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("mismatch: expected cmd %0d status %0d attempt %0d backoff %0d,",
                                 want.cmd, want.status, want.attempt, want.backoff,
                                 " got cmd %0d status %0d attempt %0d backoff %0d",
                                 got.cmd, got.status, got.attempt, got.backoff);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          p;
        int          useful;
        int          pick;
        logic [1:0]  fn;
        logic        det;
        logic [31:0] rnd;
        logic [15:0] v_att;
        logic [15:0] v_timeout;
        logic [15:0] v_settle;
        logic [15:0] v_min;
        logic [15:0] v_max;

        reg_max_att  = RST_MAX_ATTEMPTS;
        reg_timeout  = RST_CAD_TIMEOUT;
        reg_settle   = RST_SETTLE;
        reg_base_min = RST_BASE_MIN;
        reg_base_max = RST_BASE_MAX;
        fsm_phase    = PH_IDLE;
        attempt_cnt  = '0;
        tick_cnt     = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // out-of-phase events, unknown func, then a clean free result at reset settings
        plan.push_back(row_chk(FN_TICK, 1'b0, 32'h0, mk_res(CMD_NONE, ST_RUN, 4'd0, 16'd0)));
        plan.push_back(row_chk(FN_DONE, 1'b1, 32'h0, mk_res(CMD_NONE, ST_RUN, 4'd0, 16'd0)));
        plan.push_back(row_chk(FN_UNUSED, 1'b1, 32'hFFFF_FFFF,
                               mk_res(CMD_NONE, ST_RUN, 4'd0, 16'd0)));
        plan.push_back(row_chk(FN_START, 1'b0, 32'h0, mk_res(CMD_IDLE, ST_RUN, 4'd0, 16'd0)));
        plan.push_back(row_beat(FN_TICK, 1'b0, 32'h0));
        plan.push_back(row_beat(FN_TICK, 1'b0, 32'h0));
        plan.push_back(row_chk(FN_DONE, 1'b0, 32'h0, mk_res(CMD_NONE, ST_FREE, 4'd0, 16'd0)));
        // zero attempts, shortest counts, inverted window
        plan.push_back(row_reg(REG_MAX_ATTEMPTS, 16'd0));
        plan.push_back(row_reg(REG_CAD_TIMEOUT, 16'd1));
        plan.push_back(row_reg(REG_SETTLE, 16'd1));
        plan.push_back(row_reg(REG_BASE_MIN, 16'd3));
        plan.push_back(row_reg(REG_BASE_MAX, 16'd2));
        plan.push_back(row_chk(FN_START, 1'b0, 32'h0, mk_res(CMD_IDLE, ST_RUN, 4'd0, 16'd0)));
        plan.push_back(row_beat(FN_TICK, 1'b0, 32'h0));
        plan.push_back(row_chk(FN_TICK, 1'b0, 32'h0, mk_res(CMD_IDLE, ST_FAIL, 4'd1, 16'd0)));
        plan.push_back(row_chk(FN_START, 1'b0, 32'h0, mk_res(CMD_IDLE, ST_RUN, 4'd0, 16'd0)));
        plan.push_back(row_beat(FN_TICK, 1'b0, 32'h0));
        plan.push_back(row_beat(FN_DONE, 1'b1, 32'h0));
        plan.push_back(row_beat(FN_TICK, 1'b0, 32'h0));
        plan.push_back(row_beat(FN_TICK, 1'b0, 32'h0));
        plan.push_back(row_chk(FN_TICK, 1'b0, 32'h0, mk_res(CMD_IDLE, ST_FAIL, 4'd1, 16'd0)));
        // highest window bounds (a one-value window) at the third attempt, then restart during backoff
        plan.push_back(row_reg(REG_MAX_ATTEMPTS, 16'd15));
        plan.push_back(row_reg(REG_BASE_MIN, 16'd16383));
        plan.push_back(row_reg(REG_BASE_MAX, 16'd16383));
        plan.push_back(row_beat(FN_START, 1'b0, 32'h0));
        plan.push_back(row_beat(FN_TICK, 1'b0, 32'h0));
        plan.push_back(row_beat(FN_TICK, 1'b0, 32'h0));
        plan.push_back(row_beat(FN_TICK, 1'b0, 32'h0));
        plan.push_back(row_beat(FN_TICK, 1'b0, 32'h0));
        plan.push_back(row_beat(FN_TICK, 1'b0, 32'h0));
        plan.push_back(row_beat(FN_DONE, 1'b1, 32'hFFFF_FFFF));
        plan.push_back(row_chk(FN_START, 1'b0, 32'h0, mk_res(CMD_IDLE, ST_RUN, 4'd0, 16'd0)));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                drain();
                cfg_write(plan[i].addr, plan[i].wdata);
            end
            else
                send_event(plan[i].fn, plan[i].det, plan[i].rnd, plan[i].typed, plan[i].res);
        end

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            case (p)
                1:
                begin
                    v_att = 16'd15; v_timeout = 16'd65535; v_settle = 16'd1;
                    v_min = 16'd16383; v_max = 16'd16383;
                end
                3:
                begin
                    v_att = 16'd2; v_timeout = 16'd3; v_settle = 16'd255;
                    v_min = 16'd1; v_max = 16'd16383;
                end
                5:
                begin
                    v_att = 16'd1; v_timeout = 16'd1; v_settle = 16'd1;
                    v_min = 16'd1; v_max = 16'd1;
                end
                default:
                begin
                    v_att = 16'($urandom_range(0, 15));
                    v_timeout = 16'($urandom_range(1, 10));
                    v_settle = 16'($urandom_range(1, 4));
                    v_min = 16'($urandom_range(1, 30));
                    v_max = 16'($urandom_range(1, 60));
                end
            endcase
            cfg_write(REG_MAX_ATTEMPTS, v_att);
            cfg_write(REG_CAD_TIMEOUT, v_timeout);
            cfg_write(REG_SETTLE, v_settle);
            cfg_write(REG_BASE_MIN, v_min);
            cfg_write(REG_BASE_MAX, v_max);

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase

            useful = 0;
            while (useful < PHASE_EVENTS)
            begin
                if ($urandom_range(0, 99) == 0)
                    drain();
                pick = $urandom_range(0, 99);
                det = 1'($urandom_range(0, 1));
                rnd = $urandom;
                if (pick < 3)
                    fn = FN_UNUSED;
                else if (pick < 5)
                    fn = FN_START;
                else if (pick < 9)
                    fn = FN_DONE;
                else if (pick < 11)
                    fn = FN_TICK;
                else
                begin
                    case (fsm_phase)
                        PH_IDLE: fn = FN_START;
                        PH_DETECT:
                        begin
                            fn = (pick < 40) ? FN_TICK : FN_DONE;
                            det = (pick < 80);
                        end
                        default: fn = FN_TICK;
                    endcase
                end
                if (!(fn == FN_UNUSED || (fn == FN_TICK && fsm_phase == PH_IDLE) ||
                      (fn == FN_DONE && fsm_phase != PH_DETECT)))
                    useful++;
                send_event(fn, det, rnd, 1'b0, '0);
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (bad_beats == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
